>>> sv/nlp_pkg.sv
// ----------------------------------------------------------------------------
// nlp_pkg: shared types for the next lexicographic permutation unit
// Word width, queue tag and status types, and the back-end state encoding.
// ----------------------------------------------------------------------------
package nlp_pkg;

   localparam int WORD_W = 32;
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // word as classified by the front end
   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic                     last;
      logic                     keep;
      logic                     ovf;
   } nlp_tag_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } nlp_qstat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_S1_START,
      ST_S1_FIRST,
      ST_S1_STEP,
      ST_S2_START,
      ST_S2_STEP,
      ST_SWAP_J,
      ST_E_RD,
      ST_E_LD
   } nlp_state_type;

endpackage

>>> sv/nlp_if.sv
// ----------------------------------------------------------------------------
// nlp_if: channel interfaces of the permutation unit
// Request channel carries sequence words, response channel the permuted words.
// ----------------------------------------------------------------------------
interface nlp_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [nlp_pkg::WORD_W-1:0] value;
   logic                             last_in;

   modport source (output valid, output value, output last_in, input ready);
   modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface nlp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [nlp_pkg::WORD_W-1:0] result_value;
   logic                             has_next;
   logic                             overflow;
   logic                             last_out;

   modport source (output valid, output result_value, output has_next,
                   output overflow, output last_out, input ready);
   modport sink   (input valid, input result_value, input has_next,
                   input overflow, input last_out, output ready);
endinterface

>>> sv/nlp_front.sv
// ----------------------------------------------------------------------------
// nlp_front: request intake and classification
// Counts words of the current sequence, marks kept or dropped words and the
// sticky overflow, and pushes each tagged word into the queue.
// ----------------------------------------------------------------------------
module nlp_front #(
   parameter int MAX_LEN = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   nlp_req_if.sink               req,
   input  nlp_pkg::nlp_qstat_type qstat,
   output logic                  push,
   output nlp_pkg::nlp_tag_type  push_tag
);
   import nlp_pkg::*;

   localparam int CW = $clog2(MAX_LEN + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic          keep;
   logic          ovf_now;

   assign req.ready = !qstat.full;
   assign push      = req.valid && !qstat.full;
   assign keep      = cnt_ff < CW'(MAX_LEN);
   assign ovf_now   = ovf_ff || !keep;

   always_comb begin
      push_tag.value = req.value;
      push_tag.last  = req.last_in;
      push_tag.keep  = keep;
      push_tag.ovf   = ovf_now;
      cnt_in         = cnt_ff;
      ovf_in         = ovf_ff;
      if (push) begin
         if (req.last_in) begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + CW'(keep);
            ovf_in = ovf_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

>>> sv/nlp_queue.sv
// ----------------------------------------------------------------------------
// nlp_queue: short word queue between front and back end
// Two-entry FIFO of tagged words; lets intake and permutation stall apart.
// ----------------------------------------------------------------------------
module nlp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  nlp_pkg::nlp_tag_type   push_tag,
   input  logic                   pop,
   output nlp_pkg::nlp_tag_type   pop_tag,
   output nlp_pkg::nlp_qstat_type qstat
);
   import nlp_pkg::*;

   nlp_tag_type       entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign qstat.not_empty = cnt_ff != '0;
   assign qstat.full      = cnt_ff == QCNT_W'(QDEPTH);
   assign do_push         = push && !qstat.full;
   assign do_pop          = pop && qstat.not_empty;
   assign pop_tag         = entry_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? QPTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? QPTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> sv/nlp_back.sv
// ----------------------------------------------------------------------------
// nlp_back: element store, pivot search, swap and emission
// Stores kept words; on the last word scans for the pivot and, if found, its
// successor, swaps them in the store and emits with the suffix read in reverse.
// ----------------------------------------------------------------------------
module nlp_back #(
   parameter int MAX_LEN = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nlp_pkg::nlp_qstat_type qstat,
   input  nlp_pkg::nlp_tag_type   pop_tag,
   output logic                   pop,
   nlp_rsp_if.source              rsp
);
   import nlp_pkg::*;

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int EW = CW + 1;

   logic [WORD_W-1:0] elem_mem [MAX_LEN];

   nlp_state_type     state_ff, state_in;
   logic [CW-1:0]     wp_ff, wp_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [CW-1:0]     k_ff, k_in;
   logic              ovf_ff, ovf_in;
   logic              found_ff, found_in;
   logic [AW-1:0]     p_ff, p_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [WORD_W-1:0] right_ff, right_in;
   logic [WORD_W-1:0] piv_ff, piv_in;
   logic [WORD_W-1:0] rd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_next_ff, rsp_next_in;
   logic              rsp_ovf_ff, rsp_ovf_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              we;
   logic [AW-1:0]     waddr;
   logic [WORD_W-1:0] wdata;
   logic              re;
   logic [AW-1:0]     raddr;

   logic              out_free;
   logic [AW-1:0]     last_idx;
   logic [AW-1:0]     idx_dec;
   logic [CW-1:0]     base;
   logic [EW-1:0]     rev_addr;
   logic [AW-1:0]     emit_addr;
   logic              emit_last;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_value = rsp_value_ff;
   assign rsp.has_next     = rsp_next_ff;
   assign rsp.overflow     = rsp_ovf_ff;
   assign rsp.last_out     = rsp_last_ff;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign last_idx  = AW'(n_ff - CW'(1));
   assign idx_dec   = idx_ff - AW'(1);
   assign base      = found_ff ? (CW'(p_ff) + CW'(1)) : '0;
   // suffix after the pivot is emitted back to front
   assign rev_addr  = {1'b0, n_ff} + {1'b0, base} - EW'(1) - {1'b0, k_ff};
   assign emit_addr = (k_ff < base) ? k_ff[AW-1:0] : rev_addr[AW-1:0];
   assign emit_last = CW'(k_ff + CW'(1)) == n_ff;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      ovf_in       = ovf_ff;
      found_in     = found_ff;
      p_in         = p_ff;
      idx_in       = idx_ff;
      right_in     = right_ff;
      piv_in       = piv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_value_in = rsp_value_ff;
      rsp_next_in  = rsp_next_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      we           = 1'b0;
      waddr        = wp_ff[AW-1:0];
      wdata        = pop_tag.value;
      re           = 1'b0;
      raddr        = idx_dec;
      case (state_ff)
         ST_IDLE: begin
            if (qstat.not_empty) begin
               pop   = 1'b1;
               we    = pop_tag.keep;
               wp_in = wp_ff + CW'(pop_tag.keep);
               if (pop_tag.last) begin
                  n_in     = wp_ff + CW'(pop_tag.keep);
                  ovf_in   = pop_tag.ovf;
                  wp_in    = '0;
                  state_in = ST_S1_START;
               end
            end
         end
         ST_S1_START: begin
            found_in = 1'b0;
            k_in     = '0;
            if (n_ff == CW'(1)) begin
               state_in = ST_E_RD;
            end else begin
               re       = 1'b1;
               raddr    = last_idx;
               idx_in   = last_idx;
               state_in = ST_S1_FIRST;
            end
         end
         ST_S1_FIRST: begin
            right_in = rd_data_ff;
            re       = 1'b1;
            idx_in   = idx_dec;
            state_in = ST_S1_STEP;
         end
         ST_S1_STEP: begin
            if ($signed(rd_data_ff) < $signed(right_ff)) begin
               found_in = 1'b1;
               p_in     = idx_ff;
               piv_in   = rd_data_ff;
               state_in = ST_S2_START;
            end else begin
               right_in = rd_data_ff;
               if (idx_ff == '0) begin
                  state_in = ST_E_RD;
               end else begin
                  re     = 1'b1;
                  idx_in = idx_dec;
               end
            end
         end
         ST_S2_START: begin
            re       = 1'b1;
            raddr    = last_idx;
            idx_in   = last_idx;
            state_in = ST_S2_STEP;
         end
         ST_S2_STEP: begin
            if ($signed(piv_ff) < $signed(rd_data_ff)) begin
               we       = 1'b1;
               waddr    = p_ff;
               wdata    = rd_data_ff;
               state_in = ST_SWAP_J;
            end else begin
               re     = 1'b1;
               idx_in = idx_dec;
            end
         end
         ST_SWAP_J: begin
            we       = 1'b1;
            waddr    = idx_ff;
            wdata    = piv_ff;
            state_in = ST_E_RD;
         end
         ST_E_RD: begin
            re       = 1'b1;
            raddr    = emit_addr;
            state_in = ST_E_LD;
         end
         ST_E_LD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_data_ff;
               rsp_next_in  = found_ff;
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = emit_last;
               if (emit_last) begin
                  k_in     = '0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = ST_E_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         elem_mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= elem_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      ovf_ff       <= ovf_in;
      found_ff     <= found_in;
      p_ff         <= p_in;
      idx_ff       <= idx_in;
      right_ff     <= right_in;
      piv_ff       <= piv_in;
      rsp_value_ff <= rsp_value_in;
      rsp_next_ff  <= rsp_next_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

>>> sv/next_lexicographic_permutation_unit.sv
// ----------------------------------------------------------------------------
// next_lexicographic_permutation_unit: next permutation of a word sequence
// A sequence of signed words enters on req_ch, one word per handshake, the
// final word flagged by last_in. The next lexicographically greater order of
// the stored words leaves on rsp_ch, one word per handshake, with has_next,
// overflow and last_out. Words beyond MAX_LEN are dropped and flagged.
//
// Intake passes each word through a two-entry queue, so req_ch keeps
// moving while a result is still being emitted, until the queue fills.
// After the last word the back end works on its store, one read or write
// at a time: a pivot scan, a successor scan that writes the successor over
// the pivot, a second write to finish the swap, then a read and an output
// load for each emitted word.
//
// Reset clears the queue, sequence counters and the output valid flag; the
// store is not cleared. When rsp_ch stalls, the output word holds and the
// back end waits; intake continues until the queue is full.
// ----------------------------------------------------------------------------
module next_lexicographic_permutation_unit #(
   parameter int MAX_LEN = 16
) (
   input  logic      clock,
   input  logic      reset,
   nlp_req_if.sink   req_ch,
   nlp_rsp_if.source rsp_ch
);
   import nlp_pkg::*;

   logic          push;
   nlp_tag_type   push_tag;
   logic          pop;
   nlp_tag_type   pop_tag;
   nlp_qstat_type qstat;

   nlp_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .qstat    (qstat),
      .push     (push),
      .push_tag (push_tag)
   );

   nlp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_tag (push_tag),
      .pop      (pop),
      .pop_tag  (pop_tag),
      .qstat    (qstat)
   );

   nlp_back #(
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .qstat   (qstat),
      .pop_tag (pop_tag),
      .pop     (pop),
      .rsp     (rsp_ch)
   );

`ifndef SYNTH
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("push into full queue");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> qstat.not_empty)
      else $error("pop from empty queue");

   a_drop_flag: assert property (@(posedge clock) disable iff (reset)
      push && !push_tag.keep |-> push_tag.ovf)
      else $error("dropped word without overflow mark");

   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid after reset");
`endif

endmodule

>>> dv/next_lexicographic_permutation_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_lexicographic_permutation_unit_tb: self-checking bench for the unit
// Sends signed word sequences on req_ch and predicts the next permutation of
// each one, including has_next, overflow and last_out. Every word taken from
// rsp_ch is compared with the oldest predicted word. Directed sequences cover
// single words, wraps, signed extremes and duplicates. Random sequences cover
// full, overflowing and sorted stores. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module next_lexicographic_permutation_unit_tb;
   import nlp_pkg::*;

   localparam int MAX_LEN = 16;
   localparam int RAND_WORDS = 300;
   localparam int CALM_WORDS = 260;
   localparam int DRAIN_CYCLES = 200;
   localparam logic signed [WORD_W-1:0] S_MIN = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] S_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic signed [WORD_W-1:0] value;
      bit                       has_next;
      bit                       overflow;
      bit                       last_out;
   } perm_word_type;

   class next_perm_scoreboard;
      logic signed [WORD_W-1:0] elems[MAX_LEN];
      int                       count;
      bit                       dropped;
      perm_word_type            expected_words[$];
      int                       errors;

      function new();
         count = 0;
         dropped = 0;
         errors = 0;
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         errors++;
      endtask

      function void swap_elems(int a, int b);
         logic signed [WORD_W-1:0] t;
         t = elems[a];
         elems[a] = elems[b];
         elems[b] = t;
      endfunction

      function void reverse_elems(int lo, int hi);
         while (lo < hi) begin
            swap_elems(lo, hi);
            lo++;
            hi--;
         end
      endfunction

      // rearranges the first n elements, returns 1 if a greater order existed
      function bit advance_permutation(int n);
         int pivot;
         int j;
         pivot = -1;
         for (int i = n - 1; i > 0; i--) begin
            if (elems[i-1] < elems[i]) begin
               pivot = i - 1;
               break;
            end
         end
         if (pivot < 0) begin
            reverse_elems(0, n - 1);
            return 0;
         end
         j = n - 1;
         while (j > pivot && !(elems[pivot] < elems[j])) j--;
         swap_elems(pivot, j);
         reverse_elems(pivot + 1, n - 1);
         return 1;
      endfunction

      function void note_word(logic signed [WORD_W-1:0] value, bit last);
         perm_word_type w;
         bit            nxt;
         if (count < MAX_LEN) begin
            elems[count] = value;
            count++;
         end else begin
            dropped = 1;
         end
         if (last) begin
            nxt = advance_permutation(count);
            for (int k = 0; k < count; k++) begin
               w.value = elems[k];
               w.has_next = nxt;
               w.overflow = dropped;
               w.last_out = (k == count - 1);
               expected_words = {expected_words, w};
            end
            count = 0;
            dropped = 0;
         end
      endfunction

      task check_word(logic signed [WORD_W-1:0] value, bit has_next, bit overflow,
                      bit last_out);
         perm_word_type w;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word value=%0d", value));
            return;
         end
         w = expected_words.pop_front();
         if (value !== w.value)
            report($sformatf("result_value got %0d exp %0d", value, w.value));
         if (has_next !== w.has_next)
            report($sformatf("has_next got %0b exp %0b", has_next, w.has_next));
         if (overflow !== w.overflow)
            report($sformatf("overflow got %0b exp %0b", overflow, w.overflow));
         if (last_out !== w.last_out)
            report($sformatf("last_out got %0b exp %0b", last_out, w.last_out));
      endtask

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;

   nlp_req_if req_if();
   nlp_rsp_if rsp_if();

   next_lexicographic_permutation_unit #(
      .MAX_LEN(MAX_LEN)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   next_perm_scoreboard      sb;
   logic signed [WORD_W-1:0] seq_q[$];

   initial clock = 0;
   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      #(400000 * 4);
      $display("DONE: errors detected");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_word(req_if.value, req_if.last_in);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_word(rsp_if.result_value, rsp_if.has_next, rsp_if.overflow,
                          rsp_if.last_out);
      end
   end

   // response side: random stall bursts, none once calm
   initial begin
      rsp_if.ready = 0;
      forever begin
         @(negedge clock);
         if (!reset && !calm && $urandom_range(0, 4) == 0) begin
            rsp_if.ready = 0;
            repeat ($urandom_range(1, 8) - 1) @(negedge clock);
         end else begin
            rsp_if.ready = !reset;
         end
      end
   end

   task send_word(logic signed [WORD_W-1:0] value, bit last);
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_if.valid = 0;
         req_if.value = $urandom();
         req_if.last_in = $urandom_range(0, 1);
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_if.valid = 1;
      req_if.value = value;
      req_if.last_in = last;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task send_seq();
      for (int i = 0; i < seq_q.size(); i++)
         send_word(seq_q[i], i == seq_q.size() - 1);
      seq_q.delete();
   endtask

   task wait_drained();
      @(negedge clock);
      req_if.valid = 0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function logic signed [WORD_W-1:0] pick_value(int mode);
      case (mode)
         0: return $signed($urandom_range(0, 6)) - 3;
         2: begin
            case ($urandom_range(0, 5))
               0: return S_MIN;
               1: return S_MIN + 1;
               2: return -1;
               3: return 0;
               4: return 1;
               default: return S_MAX;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   initial begin
      int sent;
      int len;
      int mode;
      int r;
      int guard;

      sb = new();
      calm = 0;
      req_if.valid = 0;
      req_if.value = '0;
      req_if.last_in = 0;
      reset = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      seq_q = '{32'sd5};                 send_seq();
      seq_q = '{32'sd1, 32'sd2, 32'sd3}; send_seq();
      seq_q = '{32'sd3, 32'sd2, 32'sd1}; send_seq();
      seq_q = '{S_MIN, S_MAX};           send_seq();
      seq_q = '{S_MAX, S_MIN};           send_seq();
      seq_q = '{-32'sd1, 32'sd1};        send_seq();
      seq_q = '{32'sd0, -32'sd1};        send_seq();
      seq_q = '{32'sd7, 32'sd7, 32'sd7}; send_seq();
      seq_q = '{32'sd1, 32'sd1, 32'sd2}; send_seq();
      wait_drained();

      sent = 0;
      while (sent < RAND_WORDS) begin
         r = $urandom_range(0, 19);
         if (r < 14)      len = $urandom_range(1, 6);
         else if (r < 16) len = $urandom_range(7, MAX_LEN - 1);
         else if (r < 18) len = MAX_LEN;
         else             len = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
         mode = $urandom_range(0, 3);
         for (int i = 0; i < len; i++)
            seq_q = {seq_q, pick_value(mode == 3 ? 0 : mode)};
         if (mode == 3) seq_q.rsort();
         if (sent >= CALM_WORDS) calm = 1;
         send_seq();
         sent += len;
         if (!calm && $urandom_range(0, 9) == 0) wait_drained();
      end
      @(negedge clock);
      req_if.valid = 0;

      guard = 0;
      while (sb.pending() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      if (sb.pending() != 0) begin
         $display("DONE: errors detected");
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (sb.errors == 0) begin
            $display("DONE: 0 errors");
         end else begin
            $display("DONE: errors detected");
         end
      end
      $finish;
   end
endmodule

>>> filelist.f
sv/nlp_pkg.sv
sv/nlp_if.sv
sv/nlp_front.sv
sv/nlp_queue.sv
sv/nlp_back.sv
sv/next_lexicographic_permutation_unit.sv
dv/next_lexicographic_permutation_unit_tb.sv
